@@ rtl/dpnt4_pkg.sv @@
// Package for the discrete process noise unit: sizes, item types, command
// codes and the term table of the final series sum.
// Depends on nothing.
`timescale 1ns / 1ps

package dpnt4_pkg;

	localparam int DIM = 15;
	localparam int FRAC_BITS = 48;
	localparam int CELLS = DIM * DIM;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int SADDR_W = $clog2(4 * CELLS);
	localparam int IDX_W = $clog2(DIM);
	localparam int ACC_W = 192;
	localparam int NUM_TERMS = 15;
	localparam int TERM_W = 4;

	typedef enum logic [1:0] {
		CMD_WF  = 2'd0,
		CMD_WQ  = 2'd1,
		CMD_RUN = 2'd2,
		CMD_RD  = 2'd3
	} cmd_t;

	// Scratch banks.
	localparam logic [1:0] BANK_FQ = 2'd0;
	localparam logic [1:0] BANK_F2Q = 2'd1;
	localparam logic [1:0] BANK_F3Q = 2'd2;
	localparam logic [1:0] BANK_FQFT = 2'd3;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [3:0]         row;
		logic [3:0]         col;
		logic signed [63:0] value;
		logic [62:0]        time_step;
	} in_item_t;

	typedef struct packed {
		logic signed [63:0] read_value;
		logic               saturated;
	} out_item_t;

	typedef enum logic [1:0] {COEF_DT, COEF_C2, COEF_C3, COEF_C4} coef_t;
	typedef enum logic [1:0] {Y_Q, Y_S, Y_G0, Y_G1} ysrc_t;

	typedef struct packed {
		coef_t      coef;
		ysrc_t      ysrc;
		logic [1:0] bank;
		logic       swap;
	} term_t;

	// One product of the final sum per term; swap reads the transposed entry.
	function automatic term_t term_of(input logic [TERM_W-1:0] t);
		term_t r;
		unique case (t)
			4'd0:  r = '{COEF_DT, Y_Q, BANK_FQ, 1'b0};
			4'd1:  r = '{COEF_C2, Y_S, BANK_FQ, 1'b0};
			4'd2:  r = '{COEF_C2, Y_S, BANK_FQ, 1'b1};
			4'd3:  r = '{COEF_C3, Y_S, BANK_F2Q, 1'b0};
			4'd4:  r = '{COEF_C3, Y_S, BANK_F2Q, 1'b1};
			4'd5:  r = '{COEF_C3, Y_S, BANK_FQFT, 1'b0};
			4'd6:  r = '{COEF_C3, Y_S, BANK_FQFT, 1'b0};
			4'd7:  r = '{COEF_C4, Y_S, BANK_F3Q, 1'b0};
			4'd8:  r = '{COEF_C4, Y_S, BANK_F3Q, 1'b1};
			4'd9:  r = '{COEF_C4, Y_G0, BANK_FQ, 1'b0};
			4'd10: r = '{COEF_C4, Y_G0, BANK_FQ, 1'b0};
			4'd11: r = '{COEF_C4, Y_G0, BANK_FQ, 1'b0};
			4'd12: r = '{COEF_C4, Y_G1, BANK_FQ, 1'b0};
			4'd13: r = '{COEF_C4, Y_G1, BANK_FQ, 1'b0};
			4'd14: r = '{COEF_C4, Y_G1, BANK_FQ, 1'b0};
			default: r = '{COEF_DT, Y_Q, BANK_FQ, 1'b0};
		endcase
		return r;
	endfunction

endpackage

@@ rtl/dpnt4_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module dpnt4_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/discrete_process_noise_taylor4_unit.sv @@
// Discrete process noise unit: loads F and Q, forms the fourth-order series
// with one shared 32x32 multiplier and a 192-bit accumulator, serves results.
// Depends on dpnt4_pkg and dpnt4_ram.
//
//   channel   direction   handshake               payload
//   in        into block  in_valid / in_ready     in_data  (in_item_t)
//   out       from block  out_valid / out_ready   out_data (out_item_t)
//
// Write items go straight to ST_DONE; read items first wait in ST_RDWAIT.
// In a compute item each 64x64 product runs as four passes through the single
// 32x32 multiplier, with about 23,600 products at DIM 15 and one rounding
// state (ST_FIN) per finished sum.
// The divisions by 6 and 24 run as products with a reciprocal of 3.
// The input is ready only when the sequencer is idle; one finished item may
// wait in the output register while the next item is taken.
// Reset clears control, the output register and the result valid bits, so
// unwritten result entries read as zero.
`timescale 1ns / 1ps

module discrete_process_noise_taylor4_unit import dpnt4_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_RDWAIT, ST_FETCH, ST_LOAD, ST_MUL, ST_ADD, ST_FIN, ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		PH_FQ, PH_F2Q, PH_F3Q, PH_FQFT, PH_D2, PH_D3, PH_D4,
		PH_DIV3, PH_DIV4, PH_G0, PH_G1, PH_SUM
	} phase_t;

	localparam logic [63:0] MAX_POS = {1'b0, {63{1'b1}}};
	localparam logic [63:0] MAX_NEG = {1'b1, {63{1'b0}}};
	// Rounded-up 2^64 / 3; exact for any dividend below 2^63.
	localparam logic [63:0] RECIP3 = 64'h5555_5555_5555_5556;

	state_t              state_q;
	phase_t              phase_q;
	logic [IDX_W-1:0]    i_q, j_q, k_q;
	logic [TERM_W-1:0]   t_q;
	logic [1:0]          pc_q;
	logic [ACC_W-1:0]    acc_q;
	logic [63:0]         xm_q, ym_q, pp_q;
	logic                neg_q;
	logic [63:0]         dt_q, d2_q, d3_q, d4_q, c2_q, c3_q, c4_q, g0_q, g1_q;
	logic                flag_q;
	logic [63:0]         rd_q;
	logic                rd_ok_q;
	logic                out_valid_q;
	out_item_t           out_data_q;
	logic [CELLS-1:0]    res_valid_q;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] a,
			input logic [IDX_W-1:0] b);
		return ADDR_W'(a) * ADDR_W'(DIM) + ADDR_W'(b);
	endfunction

	function automatic logic [SADDR_W-1:0] sa(input logic [1:0] bank,
			input logic [ADDR_W-1:0] c);
		return SADDR_W'(bank) * SADDR_W'(CELLS) + SADDR_W'(c);
	endfunction

	function automatic logic [63:0] mag(input logic [63:0] x);
		return x[63] ? (~x + 64'd1) : x;
	endfunction

	// Input decode.
	logic              accept;
	logic              in_range;
	logic [ADDR_W-1:0] in_cell;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign in_range = (int'(in_data.row) < DIM) && (int'(in_data.col) < DIM);
	assign in_cell = ADDR_W'(in_data.row) * ADDR_W'(DIM) + ADDR_W'(in_data.col);

	// Memories.
	logic               f_we, q_we, s_we, r_we;
	logic [ADDR_W-1:0]  f_raddr, q_raddr, r_waddr;
	logic [SADDR_W-1:0] s_raddr, s_waddr;
	logic [63:0]        f_rdata, q_rdata, s_rdata, r_rdata;
	logic [63:0]        fin_val;
	logic               fin_sat;

	dpnt4_ram #(.WIDTH(64), .DEPTH(CELLS)) u_f_ram (
		.clk(clk), .we(f_we), .waddr(in_cell), .wdata(in_data.value),
		.raddr(f_raddr), .rdata(f_rdata)
	);

	dpnt4_ram #(.WIDTH(64), .DEPTH(CELLS)) u_q_ram (
		.clk(clk), .we(q_we), .waddr(in_cell), .wdata(in_data.value),
		.raddr(q_raddr), .rdata(q_rdata)
	);

	dpnt4_ram #(.WIDTH(64), .DEPTH(4 * CELLS)) u_s_ram (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(fin_val),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	dpnt4_ram #(.WIDTH(64), .DEPTH(CELLS)) u_r_ram (
		.clk(clk), .we(r_we), .waddr(r_waddr), .wdata(fin_val),
		.raddr(in_cell), .rdata(r_rdata)
	);

	assign f_we = accept && (in_data.cmd == CMD_WF) && in_range;
	assign q_we = accept && (in_data.cmd == CMD_WQ) && in_range;

	// Finished sums go to scratch in the matrix phases and to results at the end.
	logic mat_phase;
	logic div_phase;
	logic [1:0] dst_bank;

	assign mat_phase = (phase_q == PH_FQ) || (phase_q == PH_F2Q) ||
		(phase_q == PH_F3Q) || (phase_q == PH_FQFT);
	assign div_phase = (phase_q == PH_DIV3) || (phase_q == PH_DIV4);
	assign s_we = (state_q == ST_FIN) && mat_phase;
	assign r_we = (state_q == ST_FIN) && (phase_q == PH_SUM);
	assign r_waddr = cell_addr(i_q, j_q);

	always_comb begin
		unique case (phase_q)
			PH_FQ:   dst_bank = BANK_FQ;
			PH_F2Q:  dst_bank = BANK_F2Q;
			PH_F3Q:  dst_bank = BANK_F3Q;
			default: dst_bank = BANK_FQFT;
		endcase
	end
	assign s_waddr = sa(dst_bank, cell_addr(i_q, j_q));

	// Read addresses and operand selection for the current product.
	term_t       term;
	logic [63:0] x_sel, y_sel, coef;

	assign term = term_of(t_q);

	always_comb begin
		unique case (term.coef)
			COEF_DT: coef = dt_q;
			COEF_C2: coef = c2_q;
			COEF_C3: coef = c3_q;
			COEF_C4: coef = c4_q;
		endcase
	end

	always_comb begin
		f_raddr = '0;
		q_raddr = '0;
		s_raddr = '0;
		x_sel = '0;
		y_sel = '0;
		unique case (phase_q)
			PH_FQ: begin
				f_raddr = cell_addr(i_q, k_q);
				q_raddr = cell_addr(k_q, j_q);
				x_sel = f_rdata;
				y_sel = q_rdata;
			end
			PH_F2Q: begin
				f_raddr = cell_addr(i_q, k_q);
				s_raddr = sa(BANK_FQ, cell_addr(k_q, j_q));
				x_sel = f_rdata;
				y_sel = s_rdata;
			end
			PH_F3Q: begin
				f_raddr = cell_addr(i_q, k_q);
				s_raddr = sa(BANK_F2Q, cell_addr(k_q, j_q));
				x_sel = f_rdata;
				y_sel = s_rdata;
			end
			PH_FQFT: begin
				s_raddr = sa(BANK_FQ, cell_addr(i_q, k_q));
				f_raddr = cell_addr(j_q, k_q);
				x_sel = s_rdata;
				y_sel = f_rdata;
			end
			PH_G0: begin
				s_raddr = sa(BANK_F2Q, cell_addr(i_q, k_q));
				f_raddr = cell_addr(j_q, k_q);
				x_sel = s_rdata;
				y_sel = f_rdata;
			end
			PH_G1: begin
				s_raddr = sa(BANK_F2Q, cell_addr(j_q, k_q));
				f_raddr = cell_addr(i_q, k_q);
				x_sel = s_rdata;
				y_sel = f_rdata;
			end
			PH_D2: begin
				x_sel = dt_q;
				y_sel = dt_q;
			end
			PH_D3: begin
				x_sel = d2_q;
				y_sel = dt_q;
			end
			PH_D4: begin
				x_sel = d3_q;
				y_sel = dt_q;
			end
			// Division by 6 is a halving and then a division by 3.
			PH_DIV3: begin
				x_sel = (d3_q + 64'd3) >> 1;
				y_sel = RECIP3;
			end
			// Division by 24 is a shift by three and then a division by 3.
			PH_DIV4: begin
				x_sel = (d4_q + 64'd12) >> 3;
				y_sel = RECIP3;
			end
			PH_SUM: begin
				q_raddr = cell_addr(i_q, j_q);
				s_raddr = sa(term.bank,
					term.swap ? cell_addr(j_q, i_q) : cell_addr(i_q, j_q));
				x_sel = coef;
				unique case (term.ysrc)
					Y_Q:  y_sel = q_rdata;
					Y_S:  y_sel = s_rdata;
					Y_G0: y_sel = g0_q;
					Y_G1: y_sel = g1_q;
				endcase
			end
			default: begin
			end
		endcase
	end

	// Shared multiplier and accumulator datapath.
	logic [31:0]      mul_a, mul_b;
	logic [1:0]       sh;
	logic [ACC_W-1:0] addend;

	assign mul_a = pc_q[1] ? xm_q[63:32] : xm_q[31:0];
	assign mul_b = pc_q[0] ? ym_q[63:32] : ym_q[31:0];
	assign sh = {1'b0, pc_q[1]} + {1'b0, pc_q[0]};
	assign addend = {(ACC_W - 64)'(0), pp_q} << {sh, 5'b0};

	// Round half up, shift and saturate a finished sum.
	logic [ACC_W-1:0]  rounded, shr;
	logic [ACC_W-64:0] hi;
	logic              fits;

	assign rounded = acc_q + (ACC_W'(1) << (FRAC_BITS - 1));
	assign shr = ACC_W'($signed(rounded) >>> FRAC_BITS);
	assign hi = shr[ACC_W-1:63];
	assign fits = (&hi) || !(|hi);
	assign fin_sat = !fits;
	assign fin_val = fits ? shr[63:0] : (shr[ACC_W-1] ? MAX_NEG : MAX_POS);

	// Loop bounds.
	logic loop_last, i_last, j_last;

	assign i_last = (i_q == IDX_W'(DIM - 1));
	assign j_last = (j_q == IDX_W'(DIM - 1));

	always_comb begin
		priority if (phase_q == PH_SUM) begin
			loop_last = (t_q == TERM_W'(NUM_TERMS - 1));
		end else if (phase_q == PH_D2 || phase_q == PH_D3 || phase_q == PH_D4 ||
				div_phase) begin
			loop_last = 1'b1;
		end else begin
			loop_last = (k_q == IDX_W'(DIM - 1));
		end
	end

	// The output register takes a finished item when it is empty or being drained.
	logic out_load;

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// Sequencer, datapath registers and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_FQ;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			t_q <= '0;
			pc_q <= '0;
			acc_q <= '0;
			xm_q <= '0;
			ym_q <= '0;
			pp_q <= '0;
			neg_q <= 1'b0;
			dt_q <= '0;
			d2_q <= '0;
			d3_q <= '0;
			d4_q <= '0;
			c2_q <= '0;
			c3_q <= '0;
			c4_q <= '0;
			g0_q <= '0;
			g1_q <= '0;
			flag_q <= 1'b0;
			rd_q <= '0;
			rd_ok_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q <= '0;
			res_valid_q <= '0;
		end else begin
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_q <= '0;
						unique case (cmd_t'(in_data.cmd))
							CMD_WF, CMD_WQ: state_q <= ST_DONE;
							CMD_RD: begin
								rd_ok_q <= in_range && res_valid_q[in_cell];
								state_q <= ST_RDWAIT;
							end
							CMD_RUN: begin
								flag_q <= 1'b0;
								dt_q <= {1'b0, in_data.time_step};
								phase_q <= PH_FQ;
								i_q <= '0;
								j_q <= '0;
								k_q <= '0;
								t_q <= '0;
								acc_q <= '0;
								state_q <= ST_FETCH;
							end
						endcase
					end
				end
				ST_RDWAIT: begin
					rd_q <= rd_ok_q ? r_rdata : '0;
					state_q <= ST_DONE;
				end
				ST_FETCH: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					xm_q <= mag(x_sel);
					ym_q <= mag(y_sel);
					neg_q <= x_sel[63] ^ y_sel[63];
					pc_q <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					pp_q <= {32'b0, mul_a} * {32'b0, mul_b};
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					acc_q <= neg_q ? (acc_q - addend) : (acc_q + addend);
					pc_q <= pc_q + 2'd1;
					if (pc_q != 2'd3) begin
						state_q <= ST_MUL;
					end else if (loop_last) begin
						state_q <= ST_FIN;
					end else begin
						k_q <= k_q + IDX_W'(1);
						t_q <= t_q + TERM_W'(1);
						state_q <= ST_FETCH;
					end
				end
				ST_FIN: begin
					// A reciprocal product is not a rounded sum and never saturates.
					flag_q <= flag_q | (fin_sat && !div_phase);
					acc_q <= '0;
					k_q <= '0;
					t_q <= '0;
					state_q <= (phase_q == PH_SUM && i_last && j_last) ? ST_DONE : ST_FETCH;
					unique case (phase_q)
						PH_FQ, PH_F2Q, PH_F3Q, PH_FQFT: begin
							if (j_last) begin
								j_q <= '0;
								if (i_last) begin
									i_q <= '0;
									unique case (phase_q)
										PH_FQ:   phase_q <= PH_F2Q;
										PH_F2Q:  phase_q <= PH_F3Q;
										PH_F3Q:  phase_q <= PH_FQFT;
										default: phase_q <= PH_D2;
									endcase
								end else begin
									i_q <= i_q + IDX_W'(1);
								end
							end else begin
								j_q <= j_q + IDX_W'(1);
							end
						end
						PH_D2: begin
							d2_q <= fin_val;
							c2_q <= (fin_val + 64'd1) >> 1;
							phase_q <= PH_D3;
						end
						PH_D3: begin
							d3_q <= fin_val;
							phase_q <= PH_D4;
						end
						PH_D4: begin
							d4_q <= fin_val;
							phase_q <= PH_DIV3;
						end
						// The quotient is the upper 64 bits of the reciprocal product.
						PH_DIV3: begin
							c3_q <= acc_q[127:64];
							phase_q <= PH_DIV4;
						end
						PH_DIV4: begin
							c4_q <= acc_q[127:64];
							phase_q <= PH_G0;
							i_q <= '0;
							j_q <= '0;
						end
						PH_G0: begin
							g0_q <= fin_val;
							phase_q <= PH_G1;
						end
						PH_G1: begin
							g1_q <= fin_val;
							phase_q <= PH_SUM;
						end
						PH_SUM: begin
							res_valid_q[r_waddr] <= 1'b1;
							phase_q <= PH_G0;
							if (j_last) begin
								j_q <= '0;
								if (i_last) begin
									i_q <= '0;
								end else begin
									i_q <= i_q + IDX_W'(1);
								end
							end else begin
								j_q <= j_q + IDX_W'(1);
							end
						end
						default: begin
						end
					endcase
				end
				ST_DONE: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						out_data_q <= '{read_value: rd_q, saturated: flag_q};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

`ifndef SYNTHESIS
	// The fourth partial product ends a product: fetch the next one or finish.
	a_mac_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD && pc_q == 2'd3) |=> (state_q == ST_FETCH || state_q == ST_FIN))
		else $error("product did not end after four partial products");

	// A waiting result item holds still until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("result item changed while waiting");

	// A compute item starts with a clear saturation flag.
	a_flag_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.cmd == CMD_RUN) |=> !flag_q)
		else $error("saturation flag not cleared at compute start");

	// Handing an item to the output returns the sequencer to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && (!out_valid_q || out_ready)) |=> (out_valid_q && in_ready))
		else $error("finished item not handed to the output");
`endif

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for discrete_process_noise_taylor4_unit.
// Loads F and Q with random matrices, runs computes and reads back Qd, all
// against a bit-exact predictor. Depends on dpnt4_pkg and the unit's RTL.
`timescale 1ns / 1ps

module testbench;
	import dpnt4_pkg::*;

	typedef logic signed [63:0] mat_t [CELLS];

	localparam int WATCHDOG_LIMIT = 1000000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	discrete_process_noise_taylor4_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #2 clk = ~clk;

	// Predictor state: the loaded matrices, the series result and its flag.
	mat_t f_mat, q_mat, qd_mat;
	logic sat_flag;

	in_item_t  pending_q [$];
	out_item_t qd_expect_q [$];
	int        errors = 0;
	int        items_sent = 0;
	int        computes_done = 0;
	int        sat_results = 0;
	int        in_gap = 0;
	int        out_stall = 0;
	int        idle_cycles = 0;
	int        draw;

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Exact signed 64x64 product added into the wide accumulator.
	function automatic void mac(inout logic signed [191:0] acc, input logic [63:0] x,
			input logic [63:0] y);
		logic [127:0] p;
		p = {{64{x[63]}}, x} * {{64{y[63]}}, y};
		acc = acc + {{64{p[127]}}, p};
	endfunction

	// Round half up, drop the fraction and saturate to 64 bits.
	function automatic logic [63:0] round_sat(input logic signed [191:0] acc);
		logic signed [191:0] t;
		t = acc + (192'sd1 <<< (FRAC_BITS - 1));
		t = t >>> FRAC_BITS;
		if (t[191:63] == '0 || &t[191:63])
			return t[63:0];
		sat_flag = 1'b1;
		return t[191] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
	endfunction

	function automatic logic [63:0] fx_mul(input logic [63:0] x, input logic [63:0] y);
		logic signed [191:0] acc;
		acc = '0;
		mac(acc, x, y);
		return round_sat(acc);
	endfunction

	// d = a * b, or a * b^T when tr is set; each entry rounded on its own.
	function automatic void mat_prod(output mat_t d, input mat_t a, input mat_t b,
			input bit tr);
		logic signed [191:0] acc;
		for (int i = 0; i < DIM; i++)
			for (int j = 0; j < DIM; j++) begin
				acc = '0;
				for (int k = 0; k < DIM; k++)
					mac(acc, a[i*DIM+k], tr ? b[j*DIM+k] : b[k*DIM+j]);
				d[i*DIM+j] = round_sat(acc);
			end
	endfunction

	// Fourth-order discrete noise series for time step dt.
	function automatic void series_qd(input logic [62:0] ts);
		mat_t fq, f2q, f3q, fqft, g;
		logic [63:0] dt, d2, d3, d4, c2, c3, c4;
		logic signed [191:0] acc;
		int ij, ji;
		dt = {1'b0, ts};
		sat_flag = 1'b0;
		mat_prod(fq, f_mat, q_mat, 1'b0);
		mat_prod(f2q, f_mat, fq, 1'b0);
		mat_prod(f3q, f_mat, f2q, 1'b0);
		mat_prod(fqft, fq, f_mat, 1'b1);
		mat_prod(g, f2q, f_mat, 1'b1);
		d2 = fx_mul(dt, dt);
		d3 = fx_mul(d2, dt);
		d4 = fx_mul(d3, dt);
		c2 = (d2 + 64'd1) / 64'd2;
		c3 = (d3 + 64'd3) / 64'd6;
		c4 = (d4 + 64'd12) / 64'd24;
		for (int i = 0; i < DIM; i++)
			for (int j = 0; j < DIM; j++) begin
				ij = i*DIM + j;
				ji = j*DIM + i;
				acc = '0;
				mac(acc, dt, q_mat[ij]);
				mac(acc, c2, fq[ij]);
				mac(acc, c2, fq[ji]);
				mac(acc, c3, f2q[ij]);
				mac(acc, c3, f2q[ji]);
				mac(acc, c3, fqft[ij]);
				mac(acc, c3, fqft[ij]);
				mac(acc, c4, f3q[ij]);
				mac(acc, c4, f3q[ji]);
				for (int r = 0; r < 3; r++) begin
					mac(acc, c4, g[ij]);
					mac(acc, c4, g[ji]);
				end
				qd_mat[ij] = round_sat(acc);
			end
	endfunction

	// Applies one accepted item to the predictor and queues its result.
	function automatic void predict_item(input in_item_t it);
		out_item_t res;
		bit in_range;
		int idx;
		in_range = (it.row < DIM) && (it.col < DIM);
		idx = it.row * DIM + it.col;
		res.read_value = '0;
		case (cmd_t'(it.cmd))
			CMD_WF: if (in_range) f_mat[idx] = it.value;
			CMD_WQ: if (in_range) q_mat[idx] = it.value;
			CMD_RUN: begin
				series_qd(it.time_step);
				computes_done++;
			end
			CMD_RD: if (in_range) res.read_value = qd_mat[idx];
		endcase
		res.saturated = sat_flag;
		if (res.saturated)
			sat_results++;
		qd_expect_q.push_back(res);
	endfunction

	// The top bit of ts is dropped: the time step field is 63 bits wide.
	function automatic void add_item(input cmd_t c, input int r, input int k,
			input logic [63:0] v, input logic [63:0] ts);
		in_item_t it;
		it.cmd = c;
		it.row = r[3:0];
		it.col = k[3:0];
		it.value = v;
		it.time_step = ts[62:0];
		pending_q.push_back(it);
	endfunction

	// An item that does nothing useful: a read anywhere or a write off the matrix.
	function automatic void add_noise();
		int r;
		r = $urandom_range(0, 2);
		if (r == 0)
			add_item(CMD_RD, $urandom_range(0, 15), $urandom_range(0, 15), rand64(),
				rand64());
		else
			add_item(r == 1 ? CMD_WF : CMD_WQ, 15, $urandom_range(0, 15), rand64(),
				rand64());
	endfunction

	// Driver: presents pending items, back to back in some stretches and with a random gap between items in others.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			in_gap <= 0;
		end else begin
			if (!in_valid || in_ready) begin
				if (in_valid) begin
					predict_item(in_data);
					items_sent++;
				end
				if (in_gap == 0 && pending_q.size() > 0) begin
					in_data <= pending_q.pop_front();
					in_valid <= 1'b1;
					in_gap <= ((items_sent / 150) % 3 == 0) ? 0 : $urandom_range(0, 13);
				end else begin
					in_valid <= 1'b0;
					if (in_gap > 0)
						in_gap <= in_gap - 1;
				end
			end
		end
	end

	// Monitor: checks each result item and stalls the output at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_stall <= 0;
		end else if (out_valid && out_ready) begin
			if (qd_expect_q.size() == 0) begin
				$error("Result item with nothing expected: read_value %h", out_data.read_value);
				errors++;
			end else begin
				if (out_data.read_value !== qd_expect_q[0].read_value) begin
					$error("read_value: expected %h, got %h", qd_expect_q[0].read_value,
						out_data.read_value);
					errors++;
				end
				if (out_data.saturated !== qd_expect_q[0].saturated) begin
					$error("saturated: expected %b, got %b", qd_expect_q[0].saturated,
						out_data.saturated);
					errors++;
				end
				void'(qd_expect_q.pop_front());
			end
			draw = ((items_sent / 200) % 3 == 1) ? 0 : $urandom_range(0, 13);
			out_stall <= draw;
			out_ready <= (draw == 0);
		end else if (out_stall > 0) begin
			out_stall <= out_stall - 1;
			out_ready <= (out_stall == 1);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Watchdog on cycles without any accepted input or output item; a compute is long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout with %0d results outstanding.", qd_expect_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		logic [63:0] v;
		logic [63:0] dt;
		int shift;
		for (int i = 0; i < CELLS; i++)
			qd_mat[i] = '0;
		sat_flag = 1'b0;

		// Directed: reads before any compute, off-matrix writes and reads.
		add_item(CMD_RD, 0, 0, '1, '1);
		add_item(CMD_RD, 14, 14, '0, '0);
		add_item(CMD_RD, 15, 15, '1, '1);
		add_item(CMD_RD, 0, 15, '0, '0);
		add_item(CMD_WF, 15, 0, 64'h7FFF_FFFF_FFFF_FFFF, '1);
		add_item(CMD_WQ, 0, 15, 64'h8000_0000_0000_0000, '0);
		add_item(CMD_WF, 15, 15, '0, '1);
		add_item(CMD_RD, 14, 0, '1, '0);

		// Three problems: full load of F and Q, one compute, then reads.
		for (int p = 0; p < 3; p++) begin
			shift = (p == 0) ? 15 : (p == 1) ? 0 : 12;
			for (int i = 0; i < CELLS; i++) begin
				for (int m = 0; m < 2; m++) begin
					v = $signed(rand64()) >>> shift;
					if (p == 1 && i == 0)
						v = (m == 0) ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
					if (p == 1 && i == 1)
						v = (m == 0) ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h8000_0000_0000_0000;
					add_item(m == 0 ? CMD_WF : CMD_WQ, i / DIM, i % DIM, v, rand64());
					if ($urandom_range(0, 9) == 0)
						add_noise();
				end
			end
			dt = (p == 0) ? 64'd2814749767106 : (p == 1) ? rand64() :
				(rand64() >> 14);
			add_item(CMD_RUN, $urandom_range(0, 15), $urandom_range(0, 15), rand64(), dt);
			for (int n = 0; n < 150; n++)
				if ($urandom_range(0, 9) == 0)
					add_noise();
				else
					add_item(CMD_RD, $urandom_range(0, 14), $urandom_range(0, 14), rand64(),
						rand64());
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (pending_q.size() > 0 || in_valid || qd_expect_q.size() > 0);
		repeat (20) @(posedge clk);
		if (qd_expect_q.size() > 0) begin
			$error("%0d expected results never arrived", qd_expect_q.size());
			errors++;
		end

		$display("Sent %0d items with %0d computes; %0d results carried the saturation flag.",
			items_sent, computes_done, sat_results);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/dpnt4_pkg.sv
rtl/dpnt4_ram.sv
rtl/discrete_process_noise_taylor4_unit.sv
verif/testbench.sv
